/* src/h264rtp_pkg.sv */
// Shared types and constants for the H.264 RTP depacketizer core.
// Used by h264rtp_front, h264rtp_queue, h264rtp_back and the top level.
// No dependencies.
package h264rtp_pkg;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_COMMIT  = 2'd1;
    localparam logic [1:0] KIND_DISCARD = 2'd2;

    localparam logic [4:0] NAL_IDR        = 5'd5;
    localparam logic [4:0] NAL_SINGLE_MAX = 5'd23;
    localparam logic [4:0] NAL_FU_A       = 5'd28;
    localparam logic [11:0] FU_MIN_LEN    = 12'd2;

    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    // slots of one item's result run, emitted lowest first
    localparam int SLOT_DISC  = 0;
    localparam int SLOT_SC0   = 1;
    localparam int SLOT_SC1   = 2;
    localparam int SLOT_SC2   = 3;
    localparam int SLOT_SC3   = 4;
    localparam int SLOT_DATA  = 5;
    localparam int SLOT_CLOSE = 6;
    localparam int NUM_SLOTS  = 7;

    typedef enum logic [3:0] {
        MODE_IGNORE  = 4'b0001,
        MODE_SINGLE  = 4'b0010,
        MODE_FU_HDR  = 4'b0100,
        MODE_FU_DATA = 4'b1000
    } mode_t;

    typedef struct packed {
        logic        disc_first;
        logic        start_code;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic        close_valid;
        logic        close_commit;
        logic        key;
        logic [31:0] ts;
    } cmd_t;

endpackage

/* src/h264rtp_front.sv */
// Front end: accepts payload items, tracks packet/fragment/frame state and
// emits at most one result command per item. Depends on h264rtp_pkg.
module h264rtp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic                q_full,
    input  logic                action,
    input  logic [7:0]          data_byte,
    input  logic                first_byte,
    input  logic                last_byte,
    input  logic [11:0]         payload_length,
    input  logic                marker,
    input  logic [31:0]         rtp_timestamp,
    output logic                in_ready,
    output logic                push,
    output h264rtp_pkg::cmd_t   cmd
);

    logic [31:0]        cur_ts_reg, cur_ts_next;
    logic               ts_valid_reg, ts_valid_next;
    logic               inside_reg, inside_next;
    logic               idr_reg, idr_next;
    logic               await_reg, await_next;
    logic               nonempty_reg, nonempty_next;
    h264rtp_pkg::mode_t mode_reg, mode_next;
    logic [2:0]         hdr_bits_reg, hdr_bits_next;
    logic               fend_reg, fend_next;
    logic               fidr_reg, fidr_next;

    logic accept;
    logic [4:0] nal_type;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign nal_type = data_byte[4:0];

    always_comb begin
        cur_ts_next   = cur_ts_reg;
        ts_valid_next = ts_valid_reg;
        inside_next   = inside_reg;
        idr_next      = idr_reg;
        await_next    = await_reg;
        nonempty_next = nonempty_reg;
        mode_next     = mode_reg;
        hdr_bits_next = hdr_bits_reg;
        fend_next     = fend_reg;
        fidr_next     = fidr_reg;
        cmd           = '0;

        if (action) begin
            cmd.disc_first = nonempty_reg;
            await_next     = 1'b1;
            nonempty_next  = 1'b0;
            ts_valid_next  = 1'b0;
            inside_next    = 1'b0;
            idr_next       = 1'b0;
            mode_next      = h264rtp_pkg::MODE_IGNORE;
            fend_next      = 1'b0;
            fidr_next      = 1'b0;
        end else begin
            if (first_byte) begin
                if (ts_valid_reg && (rtp_timestamp != cur_ts_reg) && nonempty_reg) begin
                    cmd.disc_first = 1'b1;
                    await_next     = 1'b1;
                    nonempty_next  = 1'b0;
                    inside_next    = 1'b0;
                    idr_next       = 1'b0;
                end
                cur_ts_next   = rtp_timestamp;
                ts_valid_next = 1'b1;
                fend_next     = 1'b0;
                fidr_next     = 1'b0;
                if (nal_type != 5'd0 && nal_type <= h264rtp_pkg::NAL_SINGLE_MAX) begin
                    cmd.start_code = 1'b1;
                    cmd.data_valid = 1'b1;
                    cmd.data_byte  = data_byte;
                    nonempty_next  = 1'b1;
                    if (nal_type == h264rtp_pkg::NAL_IDR) begin
                        idr_next = 1'b1;
                    end
                    mode_next = h264rtp_pkg::MODE_SINGLE;
                end else if (nal_type == h264rtp_pkg::NAL_FU_A &&
                             payload_length > h264rtp_pkg::FU_MIN_LEN) begin
                    hdr_bits_next = data_byte[7:5];
                    mode_next     = h264rtp_pkg::MODE_FU_HDR;
                end else begin
                    mode_next = h264rtp_pkg::MODE_IGNORE;
                end
            end else begin
                case (mode_reg)
                    h264rtp_pkg::MODE_SINGLE: begin
                        cmd.data_valid = 1'b1;
                        cmd.data_byte  = data_byte;
                        nonempty_next  = 1'b1;
                    end
                    h264rtp_pkg::MODE_FU_HDR: begin
                        if (data_byte[7]) begin
                            cmd.start_code = 1'b1;
                            cmd.data_valid = 1'b1;
                            cmd.data_byte  = {hdr_bits_reg, nal_type};
                            inside_next    = 1'b1;
                            nonempty_next  = 1'b1;
                        end
                        fend_next = data_byte[6];
                        fidr_next = (nal_type == h264rtp_pkg::NAL_IDR);
                        mode_next = h264rtp_pkg::MODE_FU_DATA;
                    end
                    h264rtp_pkg::MODE_FU_DATA: begin
                        if (inside_reg) begin
                            cmd.data_valid = 1'b1;
                            cmd.data_byte  = data_byte;
                            nonempty_next  = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (last_byte) begin
                if (mode_next == h264rtp_pkg::MODE_FU_DATA && fend_next) begin
                    inside_next = 1'b0;
                    if (fidr_next) begin
                        idr_next = 1'b1;
                    end
                end
                mode_next = h264rtp_pkg::MODE_IGNORE;
                fend_next = 1'b0;
                fidr_next = 1'b0;
                if (marker) begin
                    if (nonempty_next) begin
                        cmd.close_valid = 1'b1;
                        if (await_next && !idr_next) begin
                            cmd.close_commit = 1'b0;
                        end else begin
                            cmd.close_commit = 1'b1;
                            cmd.key          = idr_next;
                            cmd.ts           = cur_ts_next;
                            if (idr_next) begin
                                await_next = 1'b0;
                            end
                        end
                    end
                    nonempty_next = 1'b0;
                    idr_next      = 1'b0;
                    ts_valid_next = 1'b0;
                end
            end
        end
    end

    assign push = accept &&
                  (cmd.disc_first || cmd.start_code || cmd.data_valid || cmd.close_valid);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_ts_reg   <= '0;
            ts_valid_reg <= 1'b0;
            inside_reg   <= 1'b0;
            idr_reg      <= 1'b0;
            await_reg    <= 1'b0;
            nonempty_reg <= 1'b0;
            mode_reg     <= h264rtp_pkg::MODE_IGNORE;
            hdr_bits_reg <= '0;
            fend_reg     <= 1'b0;
            fidr_reg     <= 1'b0;
        end else if (accept) begin
            cur_ts_reg   <= cur_ts_next;
            ts_valid_reg <= ts_valid_next;
            inside_reg   <= inside_next;
            idr_reg      <= idr_next;
            await_reg    <= await_next;
            nonempty_reg <= nonempty_next;
            mode_reg     <= mode_next;
            hdr_bits_reg <= hdr_bits_next;
            fend_reg     <= fend_next;
            fidr_reg     <= fidr_next;
        end
    end

endmodule

/* src/h264rtp_queue.sv */
// Four-entry command queue between front and back end.
// Depends on h264rtp_pkg.
module h264rtp_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  h264rtp_pkg::cmd_t wr_cmd,
    input  logic              pop,
    output h264rtp_pkg::cmd_t rd_cmd,
    output logic              empty,
    output logic              full
);

    h264rtp_pkg::cmd_t mem_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;

    assign empty  = (count_reg == 3'd0);
    assign full   = (count_reg == 3'd4);
    assign rd_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + 2'(push);
        rd_ptr_next = rd_ptr_reg + 2'(pop);
        count_next  = count_reg + 3'(push) - 3'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* src/h264rtp_back.sv */
// Back end: expands queued commands into result items, one per cycle unless
// the output stalls, into a registered output stage. Depends on h264rtp_pkg.
module h264rtp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  h264rtp_pkg::cmd_t cmd,
    input  logic              q_empty,
    output logic              pop,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [1:0]        out_kind,
    output logic [7:0]        out_byte,
    output logic              out_key,
    output logic [31:0]       out_ts,
    output logic              out_last
);

    localparam int NS = h264rtp_pkg::NUM_SLOTS;

    logic          busy_reg, busy_next;
    logic [NS-1:0] mask_reg, mask_next;
    logic          valid_reg;
    logic [1:0]    kind_reg, kind_next;
    logic [7:0]    byte_reg, byte_next;
    logic          key_reg, key_next;
    logic [31:0]   ts_reg, ts_next;
    logic          last_reg, last_next;

    logic [NS-1:0] head_mask, cur_mask, pick, rest;
    logic          advance;

    always_comb begin
        head_mask = '0;
        head_mask[h264rtp_pkg::SLOT_DISC]  = cmd.disc_first;
        head_mask[h264rtp_pkg::SLOT_SC0]   = cmd.start_code;
        head_mask[h264rtp_pkg::SLOT_SC1]   = cmd.start_code;
        head_mask[h264rtp_pkg::SLOT_SC2]   = cmd.start_code;
        head_mask[h264rtp_pkg::SLOT_SC3]   = cmd.start_code;
        head_mask[h264rtp_pkg::SLOT_DATA]  = cmd.data_valid;
        head_mask[h264rtp_pkg::SLOT_CLOSE] = cmd.close_valid;
    end

    assign cur_mask = busy_reg ? mask_reg : head_mask;
    assign pick     = cur_mask & (~cur_mask + NS'(1));
    assign rest     = cur_mask & ~pick;
    assign advance  = !q_empty && (!valid_reg || out_ready);
    assign pop      = advance && (rest == '0);

    always_comb begin
        kind_next = h264rtp_pkg::KIND_DATA;
        byte_next = '0;
        key_next  = 1'b0;
        ts_next   = '0;
        last_next = (rest == '0);
        if (pick[h264rtp_pkg::SLOT_DISC]) begin
            kind_next = h264rtp_pkg::KIND_DISCARD;
        end else if (pick[h264rtp_pkg::SLOT_SC0] || pick[h264rtp_pkg::SLOT_SC1] ||
                     pick[h264rtp_pkg::SLOT_SC2]) begin
            byte_next = h264rtp_pkg::SC_ZERO;
        end else if (pick[h264rtp_pkg::SLOT_SC3]) begin
            byte_next = h264rtp_pkg::SC_ONE;
        end else if (pick[h264rtp_pkg::SLOT_DATA]) begin
            byte_next = cmd.data_byte;
        end else if (pick[h264rtp_pkg::SLOT_CLOSE]) begin
            if (cmd.close_commit) begin
                kind_next = h264rtp_pkg::KIND_COMMIT;
                key_next  = cmd.key;
                ts_next   = cmd.ts;
            end else begin
                kind_next = h264rtp_pkg::KIND_DISCARD;
            end
        end
        busy_next = busy_reg;
        mask_next = mask_reg;
        if (advance) begin
            busy_next = (rest != '0);
            mask_next = rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            busy_reg  <= 1'b0;
            mask_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            mask_reg <= mask_next;
            if (advance) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            key_reg  <= key_next;
            ts_reg   <= ts_next;
            last_reg <= last_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;
    assign out_key   = key_reg;
    assign out_ts    = ts_reg;
    assign out_last  = last_reg;

endmodule

/* src/h264_rtp_depacketizer_core.sv */
// Top level of the H.264 RTP depacketizer (single NAL units and FU-A).
// Depends on h264rtp_pkg, h264rtp_front, h264rtp_queue, h264rtp_back.
//
// Usage:
//   s_ channel carries RTP payload bytes or a packet-lost event (tuser = 1).
//   tlast marks the last payload byte of a packet.
//   m_ channel carries the Annex-B stream: data bytes (tuser = 0), frame
//   commits (tuser = 1) with key flag and timestamp, and discards (tuser = 2).
//   m_tlast marks the last result caused by one input item.
// Path: an accepted item's command is written into the queue, and the back
//   end then loads its first result into the output register for m_.
// Throughput: one result item per cycle while m_tready is high, set by the
//   output register. An item with no result leaves the back end idle; an
//   item yields up to 7 results, emitted in turn before its command is popped.
//   A 4-entry command queue lets the front keep taking items meanwhile.
// Reset: all frame and packet state cleared, queue and output emptied.
// Stall: when m_tready is low the output register holds; the queue fills
//   and s_tready drops once it holds 4 commands.
module h264_rtp_depacketizer_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // data_byte[7:0], first_byte[8], payload_length[20:9], marker[21],
    // rtp_timestamp[53:22], zero fill
    input  logic [h264rtp_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                                s_tlast,   // last_byte
    input  logic                                s_tuser,   // action
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_byte[7:0], key_frame[8], frame_timestamp[40:9], zero fill
    output logic [h264rtp_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                                m_tlast,   // last_of_run
    output logic [1:0]                          m_tuser    // kind
);

    h264rtp_pkg::cmd_t wr_cmd, rd_cmd;
    logic push, pop, q_empty, q_full;
    logic [7:0]  out_byte;
    logic        out_key;
    logic [31:0] out_ts;

    h264rtp_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .q_full         (q_full),
        .action         (s_tuser),
        .data_byte      (s_tdata[7:0]),
        .first_byte     (s_tdata[8]),
        .last_byte      (s_tlast),
        .payload_length (s_tdata[20:9]),
        .marker         (s_tdata[21]),
        .rtp_timestamp  (s_tdata[53:22]),
        .in_ready       (s_tready),
        .push           (push),
        .cmd            (wr_cmd)
    );

    h264rtp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_cmd  (wr_cmd),
        .pop     (pop),
        .rd_cmd  (rd_cmd),
        .empty   (q_empty),
        .full    (q_full)
    );

    h264rtp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (rd_cmd),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_kind  (m_tuser),
        .out_byte  (out_byte),
        .out_key   (out_key),
        .out_ts    (out_ts),
        .out_last  (m_tlast)
    );

    assign m_tdata = {7'd0, out_ts, out_key, out_byte};

endmodule
